@@ src/stci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stci_pkg
// Shared types and constants for the segment/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package stci_pkg;

	// width of one packed point field on the input stream
	localparam int FIELD_W = 48;
	// number of point fields in one input transfer
	localparam int NUM_FIELDS = 5;
	// output transfer width in bits
	localparam int OUT_W = 8;

	// sign of an exact dot product
	typedef struct packed {
		logic neg;
		logic nz;
	} sign_t;

endpackage

@@ src/stci_cross.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stci_cross
// Cross product of two 3-vectors: registered partial products, then the
// combinational differences.
// ----------------------------------------------------------------------------
module stci_cross #(
	parameter int IW = 17
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [IW-1:0]       x [3],
	input  logic signed [IW-1:0]       y [3],
	output logic signed [2*IW:0]       r [3]
);

	logic signed [2*IW-1:0] pa_s2 [3];
	logic signed [2*IW-1:0] pb_s2 [3];

	// register the six partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= x[1] * y[2];
			pb_s2[0] <= x[2] * y[1];
			pa_s2[1] <= x[2] * y[0];
			pb_s2[1] <= x[0] * y[2];
			pa_s2[2] <= x[0] * y[1];
			pb_s2[2] <= x[1] * y[0];
		end
	end

	// form each component
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r[k] = (2*IW+1)'(pa_s2[k]) - (2*IW+1)'(pb_s2[k]);
		end
	end

endmodule

@@ src/stci_dot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stci_dot
// Exact sign of a 3-term dot product: registered products, then the sum.
// ----------------------------------------------------------------------------
module stci_dot
	import stci_pkg::*;
#(
	parameter int UW = 17,
	parameter int VW = 35
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [UW-1:0] u [3],
	input  logic signed [VW-1:0] v [3],
	output sign_t                sgn
);

	localparam int PW = UW + VW;
	localparam int SW = PW + 2;

	logic signed [PW-1:0] p_s4 [3];
	logic signed [SW-1:0] sum;

	// register the three products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p_s4[k] <= u[k] * v[k];
			end
		end
	end

	// exact sum and its sign
	always_comb begin
		sum = SW'(p_s4[0]) + SW'(p_s4[1]) + SW'(p_s4[2]);
		sgn.neg = sum[SW-1];
		sgn.nz  = (sum != '0);
	end

endmodule

@@ src/segment_triangle_intersect_top.sv @@
`timescale 1ns / 1ps
// Throughput: one query per cycle; a stall on the output holds every stage.
// Pipeline: differences, cross products, cross sums, dot products, signs, hit.
// Reset: arst_n clears all stage valid bits asynchronously; data needs none.
// ----------------------------------------------------------------------------
// segment_triangle_intersect_top
// Streaming segment versus triangle hit test with exact integer signs.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_top
	import stci_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// vertex_a, vertex_b, vertex_c, seg_start, seg_end (48 bits each)
	input  logic [NUM_FIELDS*FIELD_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hit in bit 0, rest zero
	output logic [OUT_W-1:0]              m_axis_tdata
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int CW = 2 * DW + 1;
	// scale does not affect the signs; fraction width is informational
	localparam int FB = FRAC_BITS;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [W-1:0] pa [3], pb [3], pc [3], ps [3], pe [3];

	logic signed [DW-1:0] ab_s1 [3], ac_s1 [3], d_s1 [3], as_s1 [3], ea_s1 [3];
	logic signed [DW-1:0] bs_s1 [3], cs_s1 [3];
	logic signed [DW-1:0] d_s2 [3], as_s2 [3], ea_s2 [3];
	logic signed [DW-1:0] d_s3 [3], as_s3 [3], ea_s3 [3];

	logic signed [CW-1:0] n_c [3], e0_c [3], e1_c [3], e2_c [3];
	logic signed [CW-1:0] n_s3 [3], e0_s3 [3], e1_s3 [3], e2_s3 [3];

	sign_t dn, an, en_sg, g0, g1, g2;
	sign_t dn_s5, an_s5, ea_s5, g0_s5, g1_s5, g2_s5;
	logic  hit_s6;

	// advance every stage unless the result is held
	assign en            = !v_s6 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, hit_s6};

	// unpack coordinates
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa[k] = s_axis_tdata[0*FIELD_W + k*W +: W];
			pb[k] = s_axis_tdata[1*FIELD_W + k*W +: W];
			pc[k] = s_axis_tdata[2*FIELD_W + k*W +: W];
			ps[k] = s_axis_tdata[3*FIELD_W + k*W +: W];
			pe[k] = s_axis_tdata[4*FIELD_W + k*W +: W];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: differences; stages 2-3: carry the short vectors along
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ab_s1[k] <= DW'(pb[k]) - DW'(pa[k]);
				ac_s1[k] <= DW'(pc[k]) - DW'(pa[k]);
				d_s1[k]  <= DW'(pe[k]) - DW'(ps[k]);
				as_s1[k] <= DW'(pa[k]) - DW'(ps[k]);
				ea_s1[k] <= DW'(pe[k]) - DW'(pa[k]);
				bs_s1[k] <= DW'(pb[k]) - DW'(ps[k]);
				cs_s1[k] <= DW'(pc[k]) - DW'(ps[k]);
				d_s2[k]  <= d_s1[k];
				as_s2[k] <= as_s1[k];
				ea_s2[k] <= ea_s1[k];
				d_s3[k]  <= d_s2[k];
				as_s3[k] <= as_s2[k];
				ea_s3[k] <= ea_s2[k];
			end
		end
	end

	// stage 2: normal and edge cross products
	stci_cross #(.IW(DW)) u_cross_n  (.clk(clk), .en(en), .x(ab_s1), .y(ac_s1), .r(n_c));
	stci_cross #(.IW(DW)) u_cross_e0 (.clk(clk), .en(en), .x(as_s1), .y(bs_s1), .r(e0_c));
	stci_cross #(.IW(DW)) u_cross_e1 (.clk(clk), .en(en), .x(bs_s1), .y(cs_s1), .r(e1_c));
	stci_cross #(.IW(DW)) u_cross_e2 (.clk(clk), .en(en), .x(cs_s1), .y(as_s1), .r(e2_c));

	// stage 3: register cross results
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3  <= n_c;
			e0_s3 <= e0_c;
			e1_s3 <= e1_c;
			e2_s3 <= e2_c;
		end
	end

	// stage 4: dot products
	stci_dot #(.UW(DW), .VW(CW)) u_dot_dn (.clk(clk), .en(en), .u(d_s3),  .v(n_s3),  .sgn(dn));
	stci_dot #(.UW(DW), .VW(CW)) u_dot_an (.clk(clk), .en(en), .u(as_s3), .v(n_s3),  .sgn(an));
	stci_dot #(.UW(DW), .VW(CW)) u_dot_en (.clk(clk), .en(en), .u(ea_s3), .v(n_s3),  .sgn(en_sg));
	stci_dot #(.UW(DW), .VW(CW)) u_dot_g0 (.clk(clk), .en(en), .u(d_s3),  .v(e0_s3), .sgn(g0));
	stci_dot #(.UW(DW), .VW(CW)) u_dot_g1 (.clk(clk), .en(en), .u(d_s3),  .v(e1_s3), .sgn(g1));
	stci_dot #(.UW(DW), .VW(CW)) u_dot_g2 (.clk(clk), .en(en), .u(d_s3),  .v(e2_s3), .sgn(g2));

	// stage 5: register signs
	always_ff @(posedge clk) begin
		if (en) begin
			dn_s5 <= dn;
			an_s5 <= an;
			ea_s5 <= en_sg;
			g0_s5 <= g0;
			g1_s5 <= g1;
			g2_s5 <= g2;
		end
	end

	// stage 6: D.n must be nonzero, and every other test zero or share its sign
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6 <= dn_s5.nz
				&& (!an_s5.nz || (an_s5.neg == dn_s5.neg))
				&& (!ea_s5.nz || (ea_s5.neg == dn_s5.neg))
				&& (!g0_s5.nz || (g0_s5.neg == dn_s5.neg))
				&& (!g1_s5.nz || (g1_s5.neg == dn_s5.neg))
				&& (!g2_s5.nz || (g2_s5.neg == dn_s5.neg))
				&& (FB >= 0);
		end
	end

endmodule

@@ src/stci_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stci_checker
// Port-level checks for the intersection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module stci_checker
	import stci_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [OUT_W-1:0]              m_axis_tdata
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// accept input whenever the output side moves
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output drains");

	// accept input when no result is pending
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// padding bits of the result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:1] == '0))
		else $error("result padding not zero");

endmodule

bind segment_triangle_intersect_top stci_checker u_stci_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

@@ bench/tb_segment_triangle_intersect_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_triangle_intersect_top
// Streams segment/triangle queries through the block and checks every hit bit
// against an exact integer predictor, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_segment_triangle_intersect_top;
	import stci_pkg::*;

	localparam int CW = 16;
	localparam int QW = NUM_FIELDS * FIELD_W;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 20;

	typedef longint vec3_t [3];

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [QW-1:0] s_axis_tdata;	// vertex_a, vertex_b, vertex_c, seg_start, seg_end
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;	// hit, then zeros

	logic [OUT_W-1:0] hit_queue [$];
	int idle_pct;
	int stall_pct;
	int hold_cycles;
	int errors;
	int queries;
	int hits_seen;
	int cycles;

	segment_triangle_intersect_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// exact arithmetic helpers
	function automatic vec3_t coords(logic [FIELD_W-1:0] w);
		vec3_t v;
		for (int k = 0; k < 3; k++) v[k] = longint'($signed(w[k*CW +: CW]));
		return v;
	endfunction

	function automatic vec3_t vsub(vec3_t x, vec3_t y);
		vec3_t r;
		for (int k = 0; k < 3; k++) r[k] = x[k] - y[k];
		return r;
	endfunction

	function automatic vec3_t vcross(vec3_t x, vec3_t y);
		vec3_t r;
		r[0] = x[1] * y[2] - x[2] * y[1];
		r[1] = x[2] * y[0] - x[0] * y[2];
		r[2] = x[0] * y[1] - x[1] * y[0];
		return r;
	endfunction

	function automatic int dsign(vec3_t x, vec3_t y);
		longint d;
		d = x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
		return (d > 0) ? 1 : (d < 0) ? -1 : 0;
	endfunction

	function automatic bit same_side(int sg, int sd);
		return sg == 0 || sg == sd;
	endfunction

	// hit test: plane crossing at or between the segment ends, and inside or on every triangle edge
	function automatic logic [OUT_W-1:0] predict_hit(logic [QW-1:0] q);
		vec3_t a, b, c, s, e, n, d;
		int sd;
		bit hit;
		a = coords(q[0*FIELD_W +: FIELD_W]);
		b = coords(q[1*FIELD_W +: FIELD_W]);
		c = coords(q[2*FIELD_W +: FIELD_W]);
		s = coords(q[3*FIELD_W +: FIELD_W]);
		e = coords(q[4*FIELD_W +: FIELD_W]);
		n = vcross(vsub(b, a), vsub(c, a));
		d = vsub(e, s);
		sd = dsign(d, n);
		hit = 0;
		if (sd != 0)
			hit = same_side(dsign(vsub(a, s), n), sd)
				&& same_side(dsign(vsub(e, a), n), sd)
				&& same_side(dsign(d, vcross(vsub(a, s), vsub(b, s))), sd)
				&& same_side(dsign(d, vcross(vsub(b, s), vsub(c, s))), sd)
				&& same_side(dsign(d, vcross(vsub(c, s), vsub(a, s))), sd);
		return {{(OUT_W-1){1'b0}}, hit};
	endfunction

	function automatic logic [FIELD_W-1:0] pt(int x, int y, int z);
		logic [CW-1:0] px, py, pz;
		px = CW'(x); py = CW'(y); pz = CW'(z);
		return {pz, py, px};
	endfunction

	function automatic logic [QW-1:0] query(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
			logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] e);
		return {e, s, c, b, a};
	endfunction

	// record expectations on input transfers, check output transfers
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			hit_queue = {hit_queue, predict_hit(s_axis_tdata)};
			queries++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (hit_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				if (m_axis_tdata !== hit_queue[0]) begin
					$display("%0t: hit mismatch expected %h actual %h",
						$time, hit_queue[0], m_axis_tdata);
					errors++;
				end
				if (hit_queue[0][0]) hits_seen++;
				void'(hit_queue.pop_front());
			end
		end
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_segment_triangle_intersect_top: FAIL");
			$finish;
		end
	end

	// offer one query, hold it until the transfer happens
	task automatic send_query(logic [QW-1:0] q);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= q;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// unit triangle in z=0 and the named special cases, plus field extremes
	task automatic test_directed();
		logic [FIELD_W-1:0] a, b, c;
		a = pt(0, 0, 0);
		b = pt(256, 0, 0);
		c = pt(0, 256, 0);
		send_query(query(a, b, c, pt(64, 64, -256), pt(64, 64, 256)));	// clean hit
		send_query(query(a, b, c, pt(64, 64, 256), pt(64, 64, -256)));	// reverse direction
		send_query(query(a, b, c, pt(0, 0, 10), pt(200, 0, 10)));	// parallel
		send_query(query(a, b, c, pt(10, 10, 0), pt(100, 10, 0)));	// in plane
		send_query(query(a, b, c, pt(64, 64, 5), pt(64, 64, 5)));	// zero length
		send_query(query(a, pt(128, 0, 0), b, pt(10, 0, -9), pt(10, 0, 9)));	// degenerate
		send_query(query(a, b, c, pt(128, 0, -50), pt(128, 0, 50)));	// on edge
		send_query(query(a, b, c, pt(128, 128, -50), pt(128, 128, 50)));	// hypotenuse
		send_query(query(a, b, c, pt(0, 0, -50), pt(0, 0, 50)));	// corner
		send_query(query(a, b, c, pt(256, 0, -1), pt(256, 0, 1)));	// far corner
		send_query(query(a, b, c, pt(64, 64, -256), pt(64, 64, 0)));	// end on plane
		send_query(query(a, b, c, pt(64, 64, 0), pt(64, 64, 77)));	// start on plane
		send_query(query(a, b, c, pt(64, 64, 10), pt(64, 64, 256)));	// short of plane
		send_query(query(a, b, c, pt(300, 64, -9), pt(300, 64, 9)));	// outside
		send_query(query(a, b, c, pt(129, 129, -9), pt(129, 129, 9)));	// just outside
		send_query(query(a, b, c, pt(-1, 20, -9), pt(-1, 20, 9)));
		send_query(query(pt(-32768, -32768, 0), pt(32767, -32768, 0), pt(-32768, 32767, 0),
			pt(-32768, -32768, -32768), pt(-32768, -32768, 32767)));	// widest corner hit
		send_query(query(pt(-32768, -32768, -32768), pt(32767, 32767, -32768),
			pt(-32768, 32767, 32767), pt(32767, -32768, 32767), pt(-32768, 32767, -32768)));
		send_query(query(pt(32767, 32767, 32767), pt(-32768, 32767, 32767),
			pt(32767, -32768, -32768), pt(-32768, -32768, -32768), pt(32767, 32767, 32767)));
		send_query('0);
		send_query('1);
		send_query({(QW/2){2'b01}});
		send_query({(QW/2){2'b10}});
		go_idle();
	endtask

	function automatic int clip(longint v);
		return (v > 32767) ? 32767 : (v < -32768) ? -32768 : int'(v);
	endfunction

	// a segment aimed at a weighted point of a random triangle, or raw bits
	function automatic logic [QW-1:0] random_query();
		logic [QW-1:0] q;
		int v [3][3];
		int t [3];
		int dir [3];
		int w [3];
		int ws, span, t1, t2, mode;
		q = '0;
		if ($urandom_range(99) < 15) begin
			for (int k = 0; k < QW / 32; k++) q[k*32 +: 32] = $urandom;
			q[QW-32 +: 32] = $urandom;
			return q;
		end
		span = ($urandom_range(3) == 0) ? 16000 : 300;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) v[i][k] = $urandom_range(2*span) - span;
		mode = $urandom_range(9);
		for (int i = 0; i < 3; i++) w[i] = $urandom_range(5) - 1;
		if (mode == 0) begin w[0] = 1; w[1] = 0; w[2] = 0; end	// corner
		if (mode == 1) begin w[0] = 1; w[1] = 1; w[2] = 0; end	// edge midpoint
		ws = w[0] + w[1] + w[2];
		if (ws == 0) begin w[0] = w[0] + 1; ws = w[0] + w[1] + w[2]; end
		for (int k = 0; k < 3; k++) begin
			t[k] = (w[0]*v[0][k] + w[1]*v[1][k] + w[2]*v[2][k]) / ws;
			dir[k] = $urandom_range(2*span) - span;
		end
		t1 = $urandom_range(2);
		t2 = (mode == 2) ? 0 : $urandom_range(2);
		for (int i = 0; i < 3; i++) q[i*FIELD_W +: FIELD_W] = pt(v[i][0], v[i][1], v[i][2]);
		q[3*FIELD_W +: FIELD_W] = pt(clip(t[0] + t1*dir[0]), clip(t[1] + t1*dir[1]),
			clip(t[2] + t1*dir[2]));
		q[4*FIELD_W +: FIELD_W] = pt(clip(t[0] - t2*dir[0]), clip(t[1] - t2*dir[1]),
			clip(t[2] - t2*dir[2]));
		return q;
	endfunction

	task automatic test_random(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) send_query(random_query());
		go_idle();
	endtask

	// hold the output off while queries keep coming, so the input stalls
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 200;
		for (int i = 0; i < 60; i++) send_query(random_query());
		go_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		errors = 0;
		queries = 0;
		hits_seen = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(500, 0, 0);
		test_random(350, 80, 0);
		test_random(350, 0, 80);
		test_random(400, 38, 38);
		test_backpressure();

		while (hit_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d queries (%0d hits) across directed corner cases,", queries,
			hits_seen);
		$display("random geometry, sender gaps, output stalls and a long hold-off.");
		if (errors == 0) begin
			$display("tb_segment_triangle_intersect_top: PASS");
		end else begin
			$display("tb_segment_triangle_intersect_top: FAIL");
		end
		$finish;
	end

endmodule
